FILE: hw/rtl/qjm_pkg.sv
`timescale 1ns / 1ps
package qjm_pkg;

   localparam int IN_W     = 32;
   localparam int DUR_W    = 24;
   localparam int COEF_W   = 48;
   localparam int STATUS_W = 2;

   // slice width of the shift-add multipliers, matches the duration width
   localparam int SLICE_W  = 24;

   // quotient bits of twice the ratio: one bit more than a coefficient
   localparam int QUOT_W   = COEF_W + 1;

   // widths of the duration powers, held signed and nonnegative
   localparam int T2_W = 2 * DUR_W + 1;
   localparam int T3_W = T2_W + SLICE_W;
   localparam int T4_W = T3_W + SLICE_W;
   localparam int T5_W = T4_W + SLICE_W;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK            = 2'd0,
      STATUS_ZERO_DURATION = 2'd1,
      STATUS_SATURATED     = 2'd2
   } status_type;

endpackage

FILE: hw/rtl/qjm_req_if.sv
`timescale 1ns / 1ps
interface qjm_req_if import qjm_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic signed [IN_W-1:0]  start_position;
   logic signed [IN_W-1:0]  start_velocity;
   logic signed [IN_W-1:0]  start_accel;
   logic signed [IN_W-1:0]  end_position;
   logic signed [IN_W-1:0]  end_velocity;
   logic signed [IN_W-1:0]  end_accel;
   logic [DUR_W-1:0]        duration;

   modport source (
      output valid, start_position, start_velocity, start_accel,
             end_position, end_velocity, end_accel, duration,
      input  ready
   );
   modport sink (
      input  valid, start_position, start_velocity, start_accel,
             end_position, end_velocity, end_accel, duration,
      output ready
   );
endinterface

FILE: hw/rtl/qjm_rsp_if.sv
`timescale 1ns / 1ps
interface qjm_rsp_if import qjm_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [COEF_W-1:0]  coef0;
   logic signed [COEF_W-1:0]  coef1;
   logic signed [COEF_W-1:0]  coef2;
   logic signed [COEF_W-1:0]  coef3;
   logic signed [COEF_W-1:0]  coef4;
   logic signed [COEF_W-1:0]  coef5;
   logic [STATUS_W-1:0]       status;

   modport source (
      output valid, coef0, coef1, coef2, coef3, coef4, coef5, status,
      input  ready
   );
   modport sink (
      input  valid, coef0, coef1, coef2, coef3, coef4, coef5, status,
      output ready
   );
endinterface

FILE: hw/rtl/qjm_dly.sv
`timescale 1ns / 1ps
module qjm_dly #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             en,
   input  logic [WIDTH-1:0] din,
   output logic [WIDTH-1:0] dout
);

   logic [WIDTH-1:0] pipe_ff [DEPTH];

   // advance the whole line together with the pipeline
   always_ff @(posedge clock) begin
      if (en) begin
         pipe_ff[0] <= din;
         for (int i = 1; i < DEPTH; i++) begin
            pipe_ff[i] <= pipe_ff[i-1];
         end
      end
   end

   assign dout = pipe_ff[DEPTH-1];

endmodule

FILE: hw/rtl/qjm_mul.sv
`timescale 1ns / 1ps
module qjm_mul import qjm_pkg::*; #(
   parameter int A_W = 32
) (
   input  logic                          clock,
   input  logic                          en,
   input  logic signed [A_W-1:0]         a,
   input  logic [SLICE_W-1:0]            b,
   output logic signed [A_W+SLICE_W-1:0] p
);

   localparam int NSL  = (A_W + SLICE_W - 1) / SLICE_W;
   localparam int AE_W = NSL * SLICE_W;
   localparam int P_W  = A_W + SLICE_W;

   logic signed [AE_W-1:0]  a_ff   [NSL-1];
   logic [SLICE_W-1:0]      b_ff   [NSL-1];
   logic signed [P_W-1:0]   acc_ff [NSL];

   // one slice of a per stage, low slice first; the top slice carries the sign
   for (genvar k = 0; k < NSL; k++) begin : g_slice
      logic signed [AE_W-1:0]      a_cur;
      logic [SLICE_W-1:0]          b_cur;
      logic signed [P_W-1:0]       acc_cur;
      logic signed [SLICE_W:0]     part;
      logic signed [2*SLICE_W+1:0] prod;

      if (k == 0) begin : g_first
         assign a_cur   = AE_W'(a);
         assign b_cur   = b;
         assign acc_cur = '0;
      end else begin : g_next
         assign a_cur   = a_ff[k-1];
         assign b_cur   = b_ff[k-1];
         assign acc_cur = acc_ff[k-1];
      end

      if (k == NSL - 1) begin : g_top
         assign part = $signed({a_cur[AE_W-1], a_cur[k*SLICE_W +: SLICE_W]});
      end else begin : g_low
         assign part = $signed({1'b0, a_cur[k*SLICE_W +: SLICE_W]});
      end

      assign prod = part * $signed({1'b0, b_cur});

      always_ff @(posedge clock) begin
         if (en) begin
            acc_ff[k] <= acc_cur + (P_W'(prod) <<< (k * SLICE_W));
         end
      end

      if (k < NSL - 1) begin : g_pass
         always_ff @(posedge clock) begin
            if (en) begin
               a_ff[k] <= a_cur;
               b_ff[k] <= b_cur;
            end
         end
      end
   end

   assign p = acc_ff[NSL-1];

endmodule

FILE: hw/rtl/qjm_div.sv
`timescale 1ns / 1ps
module qjm_div import qjm_pkg::*; #(
   parameter int NUM_W = 135,
   parameter int DEN_W = 73
) (
   input  logic                     clock,
   input  logic                     en,
   input  logic signed [NUM_W-1:0]  num,
   input  logic [DEN_W-1:0]         den,
   output logic signed [COEF_W-1:0] quo,
   output logic                     sat
);

   localparam int REM_W = ((NUM_W + 1 > DEN_W + QUOT_W) ? NUM_W + 1 : DEN_W + QUOT_W) + 1;

   logic [NUM_W-1:0]   mag_ff;
   logic               neg0_ff;
   logic [DEN_W-1:0]   den0_ff;
   logic [REM_W-1:0]   rem_ff  [QUOT_W];
   logic [DEN_W-1:0]   den_ff  [QUOT_W];
   logic [QUOT_W-1:0]  quot_ff [QUOT_W+1];
   logic [QUOT_W:0]    neg_ff;
   logic [QUOT_W:0]    over_ff;
   logic signed [COEF_W-1:0] quo_ff;
   logic               sat_ff;

   // take the magnitude, then test whether twice the ratio needs more quotient bits
   always_ff @(posedge clock) begin
      if (en) begin
         mag_ff  <= num[NUM_W-1] ? NUM_W'(~num + NUM_W'(1)) : NUM_W'(num);
         neg0_ff <= num[NUM_W-1];
         den0_ff <= den;

         rem_ff[0]  <= REM_W'({mag_ff, 1'b0});
         over_ff[0] <= REM_W'({mag_ff, 1'b0}) >= (REM_W'(den0_ff) << QUOT_W);
         neg_ff[0]  <= neg0_ff;
         den_ff[0]  <= den0_ff;
         quot_ff[0] <= '0;
      end
   end

   // restoring division, one quotient bit per stage, MSB first
   for (genvar j = 1; j <= QUOT_W; j++) begin : g_bit
      logic [REM_W-1:0] cand;
      logic             fits;

      assign cand = REM_W'(den_ff[j-1]) << (QUOT_W - j);
      assign fits = rem_ff[j-1] >= cand;

      always_ff @(posedge clock) begin
         if (en) begin
            quot_ff[j] <= {quot_ff[j-1][QUOT_W-2:0], fits};
            neg_ff[j]  <= neg_ff[j-1];
            over_ff[j] <= over_ff[j-1];
         end
      end

      if (j < QUOT_W) begin : g_rem
         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[j] <= fits ? rem_ff[j-1] - cand : rem_ff[j-1];
               den_ff[j] <= den_ff[j-1];
            end
         end
      end
   end

   // round half away from zero, clamp, restore the sign
   logic [QUOT_W:0]   rnd;
   logic [QUOT_W-1:0] qr;
   logic [QUOT_W-1:0] lim;
   logic              clamp;
   logic [QUOT_W-1:0] qmag;

   assign rnd   = {1'b0, quot_ff[QUOT_W]} + (QUOT_W+1)'(1);
   assign qr    = rnd[QUOT_W:1];
   assign lim   = neg_ff[QUOT_W] ? (QUOT_W'(1) << (COEF_W - 1))
                                 : ((QUOT_W'(1) << (COEF_W - 1)) - QUOT_W'(1));
   assign clamp = over_ff[QUOT_W] || (qr > lim);
   assign qmag  = clamp ? lim : qr;

   always_ff @(posedge clock) begin
      if (en) begin
         quo_ff <= neg_ff[QUOT_W] ? COEF_W'(~qmag + QUOT_W'(1)) : COEF_W'(qmag);
         sat_ff <= clamp;
      end
   end

   assign quo = quo_ff;
   assign sat = sat_ff;

endmodule

FILE: hw/rtl/quintic_jerk_min_trajectory.sv
`timescale 1ns / 1ps
// Each accepted req transaction travels through every stage down to the response register, which drives rsp valid.
// Throughput: one transaction per clock while rsp is not stalled; the pipeline holds up to 68 in flight.
// The whole pipeline advances when the rsp register is empty or being taken.
// Reset (synchronous, active high) clears all valid bits; data registers keep values.
module quintic_jerk_min_trajectory import qjm_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input logic        clock,
   input logic        reset,
   qjm_req_if.sink    req_chan,
   qjm_rsp_if.source  rsp_chan
);

   // Value widths. C1 = dv*D - a_i*T, C0 = 2D^2 ds - 2D v_i T - a_i T^2,
   // n3/n4/n5 are the numerators before the final scaling by D^k.
   localparam int C1_W  = ((FRAC_BITS + IN_W + 1 > 2 * IN_W - 8)
                           ? FRAC_BITS + IN_W + 1 : IN_W + DUR_W) + 1;
   localparam int C1T_W = C1_W + SLICE_W;
   localparam int C0A_W = 2 * FRAC_BITS + IN_W + 2;
   localparam int C0B_W = FRAC_BITS + IN_W + DUR_W + 1;
   localparam int C0C_W = IN_W + 2 * DUR_W;
   localparam int C0M_W = (C0A_W > C0B_W) ? C0A_W : C0B_W;
   localparam int C0_W  = ((C0M_W > C0C_W) ? C0M_W : C0C_W) + 2;
   localparam int C2T2_W = IN_W + 1 + 2 * SLICE_W;
   localparam int NM_W  = (C0_W > C1T_W) ? C0_W : C1T_W;
   localparam int N_W   = ((NM_W > C2T2_W) ? NM_W : C2T2_W) + 5;
   localparam int NUM_W = N_W + 3 * FRAC_BITS;
   localparam int LAT   = 67;
   localparam int PASS_W = 3 * IN_W + 1;

   // ---------------------------------------------------------------
   // Flow control: one global advance; valid bits shift with the data.
   // ---------------------------------------------------------------
   logic             en;
   logic [LAT-1:0]   vld_ff;
   logic             rsp_valid_ff;

   assign en             = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         vld_ff       <= {vld_ff[LAT-2:0], req_chan.valid};
         rsp_valid_ff <= vld_ff[LAT-1];
      end
   end

   // ---------------------------------------------------------------
   // Stage 1: capture the transaction and form the simple differences.
   // ---------------------------------------------------------------
   logic signed [IN_W-1:0] si_ff, vi_ff, ai_ff;
   logic signed [IN_W:0]   dsp_ff, dv_ff, c2_ff;
   logic                   zero_ff;
   logic [DUR_W-1:0]       t_ff [10];

   always_ff @(posedge clock) begin
      if (en) begin
         si_ff   <= req_chan.start_position;
         vi_ff   <= req_chan.start_velocity;
         ai_ff   <= req_chan.start_accel;
         dsp_ff  <= (IN_W+1)'(req_chan.end_position) - (IN_W+1)'(req_chan.start_position);
         dv_ff   <= (IN_W+1)'(req_chan.end_velocity) - (IN_W+1)'(req_chan.start_velocity);
         c2_ff   <= (IN_W+1)'(req_chan.end_accel) - (IN_W+1)'(req_chan.start_accel);
         zero_ff <= (req_chan.duration == '0);
         t_ff[0] <= req_chan.duration;
         // keep a copy of T beside each multiplier that needs it
         for (int i = 1; i < 10; i++) begin
            t_ff[i] <= t_ff[i-1];
         end
      end
   end

   // ---------------------------------------------------------------
   // Stages 2-3: T^2, v_i T, a_i T, C2 T.
   // ---------------------------------------------------------------
   logic signed [T2_W-1:0]           t2;
   logic signed [IN_W+SLICE_W-1:0]   vt, at;
   logic signed [IN_W+SLICE_W:0]     c2t;

   qjm_mul #(.A_W(DUR_W + 1)) u_mul_t2 (
      .clock(clock), .en(en), .a($signed({1'b0, t_ff[0]})), .b(t_ff[0]), .p(t2));
   qjm_mul #(.A_W(IN_W)) u_mul_vt (
      .clock(clock), .en(en), .a(vi_ff), .b(t_ff[0]), .p(vt));
   qjm_mul #(.A_W(IN_W)) u_mul_at (
      .clock(clock), .en(en), .a(ai_ff), .b(t_ff[0]), .p(at));
   qjm_mul #(.A_W(IN_W + 1)) u_mul_c2t (
      .clock(clock), .en(en), .a(c2_ff), .b(t_ff[0]), .p(c2t));

   logic signed [IN_W:0] dv_d;

   qjm_dly #(.WIDTH(IN_W + 1), .DEPTH(2)) u_dly_dv (
      .clock(clock), .en(en), .din(dv_ff), .dout(dv_d));

   // Stage 4: C1 = dv * D - a_i T
   logic signed [C1_W-1:0] c1_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         c1_ff <= (C1_W'(dv_d) <<< FRAC_BITS) - C1_W'(at);
      end
   end

   // ---------------------------------------------------------------
   // Stages 4-15: higher powers of T and the remaining products.
   // ---------------------------------------------------------------
   logic signed [T3_W-1:0]       t3;
   logic signed [T4_W-1:0]       t4;
   logic signed [T5_W-1:0]       t5;
   logic signed [IN_W+2*SLICE_W-1:0] at2;
   logic signed [C2T2_W-1:0]     c2t2;
   logic signed [C1T_W-1:0]      c1t;

   qjm_mul #(.A_W(T2_W)) u_mul_t3 (
      .clock(clock), .en(en), .a(t2), .b(t_ff[2]), .p(t3));
   qjm_mul #(.A_W(IN_W + SLICE_W)) u_mul_at2 (
      .clock(clock), .en(en), .a(at), .b(t_ff[2]), .p(at2));
   qjm_mul #(.A_W(IN_W + SLICE_W + 1)) u_mul_c2t2 (
      .clock(clock), .en(en), .a(c2t), .b(t_ff[2]), .p(c2t2));
   qjm_mul #(.A_W(C1_W)) u_mul_c1t (
      .clock(clock), .en(en), .a(c1_ff), .b(t_ff[3]), .p(c1t));
   qjm_mul #(.A_W(T3_W)) u_mul_t4 (
      .clock(clock), .en(en), .a(t3), .b(t_ff[5]), .p(t4));
   qjm_mul #(.A_W(T4_W)) u_mul_t5 (
      .clock(clock), .en(en), .a(t4), .b(t_ff[9]), .p(t5));

   logic signed [IN_W:0]           dsp_d;
   logic signed [IN_W+SLICE_W-1:0] vt_d;
   logic signed [C2T2_W-1:0]       c2t2_d;

   qjm_dly #(.WIDTH(IN_W + 1), .DEPTH(5)) u_dly_dsp (
      .clock(clock), .en(en), .din(dsp_ff), .dout(dsp_d));
   qjm_dly #(.WIDTH(IN_W + SLICE_W), .DEPTH(3)) u_dly_vt (
      .clock(clock), .en(en), .din(vt), .dout(vt_d));
   qjm_dly #(.WIDTH(C2T2_W), .DEPTH(1)) u_dly_c2t2 (
      .clock(clock), .en(en), .din(c2t2), .dout(c2t2_d));

   // Stage 7: C0, scaled so that all terms share D^2 units times two
   logic signed [C0_W-1:0] c0_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         c0_ff <= (C0_W'(dsp_d) <<< (2 * FRAC_BITS + 1))
                - (C0_W'(vt_d) <<< (FRAC_BITS + 1))
                - C0_W'(at2);
      end
   end

   // Stage 8: numerators of a3, a4, a5 by shift-add constant scaling
   logic signed [N_W-1:0] c0e, c1te, c2e;
   logic signed [N_W-1:0] n3_ff, n4_ff, n5_ff;

   assign c0e  = N_W'(c0_ff);
   assign c1te = N_W'(c1t);
   assign c2e  = N_W'(c2t2_d);

   always_ff @(posedge clock) begin
      if (en) begin
         n3_ff <= (c0e <<< 3) + (c0e <<< 1) - (c1te <<< 3) + c2e;
         n4_ff <= c0e - (c0e <<< 4) + (c1te <<< 4) - (c1te <<< 1) - (c2e <<< 1);
         n5_ff <= (c0e <<< 2) + (c0e <<< 1) - (c1te <<< 2) - (c1te <<< 1) + c2e;
      end
   end

   // Align numerators and divisors at stage 15, where T^5 arrives.
   logic signed [N_W-1:0]  n3_d, n4_d, n5_d;
   logic signed [T3_W-1:0] t3_d;
   logic signed [T4_W-1:0] t4_d;

   qjm_dly #(.WIDTH(N_W), .DEPTH(7)) u_dly_n3 (
      .clock(clock), .en(en), .din(n3_ff), .dout(n3_d));
   qjm_dly #(.WIDTH(N_W), .DEPTH(7)) u_dly_n4 (
      .clock(clock), .en(en), .din(n4_ff), .dout(n4_d));
   qjm_dly #(.WIDTH(N_W), .DEPTH(7)) u_dly_n5 (
      .clock(clock), .en(en), .din(n5_ff), .dout(n5_d));
   qjm_dly #(.WIDTH(T3_W), .DEPTH(9)) u_dly_t3 (
      .clock(clock), .en(en), .din(t3), .dout(t3_d));
   qjm_dly #(.WIDTH(T4_W), .DEPTH(5)) u_dly_t4 (
      .clock(clock), .en(en), .din(t4), .dout(t4_d));

   // ---------------------------------------------------------------
   // Stages 16-67: three bit-per-stage dividers, round, clamp.
   // ---------------------------------------------------------------
   logic signed [NUM_W-1:0]  num3, num4, num5;
   logic [T3_W-1:0]          den3;
   logic [T4_W-1:0]          den4;
   logic [T5_W-1:0]          den5;
   logic signed [COEF_W-1:0] a3, a4, a5;
   logic                     sat3, sat4, sat5;

   assign num3 = NUM_W'(n3_d) <<< FRAC_BITS;
   assign num4 = NUM_W'(n4_d) <<< (2 * FRAC_BITS);
   assign num5 = NUM_W'(n5_d) <<< (3 * FRAC_BITS);
   assign den3 = {t3_d[T3_W-2:0], 1'b0};
   assign den4 = {t4_d[T4_W-2:0], 1'b0};
   assign den5 = {t5[T5_W-2:0], 1'b0};

   qjm_div #(.NUM_W(NUM_W), .DEN_W(T3_W)) u_div3 (
      .clock(clock), .en(en), .num(num3), .den(den3), .quo(a3), .sat(sat3));
   qjm_div #(.NUM_W(NUM_W), .DEN_W(T4_W)) u_div4 (
      .clock(clock), .en(en), .num(num4), .den(den4), .quo(a4), .sat(sat4));
   qjm_div #(.NUM_W(NUM_W), .DEN_W(T5_W)) u_div5 (
      .clock(clock), .en(en), .num(num5), .den(den5), .quo(a5), .sat(sat5));

   // carry a0, a1, a_i and the zero flag alongside to stage 67
   logic [PASS_W-1:0]      pass_d;
   logic signed [IN_W-1:0] si_d, vi_d, ai_d;
   logic                   zero_d;

   qjm_dly #(.WIDTH(PASS_W), .DEPTH(LAT - 1)) u_dly_pass (
      .clock(clock), .en(en),
      .din({si_ff, vi_ff, ai_ff, zero_ff}), .dout(pass_d));

   assign si_d   = $signed(pass_d[PASS_W-1 -: IN_W]);
   assign vi_d   = $signed(pass_d[PASS_W-1-IN_W -: IN_W]);
   assign ai_d   = $signed(pass_d[IN_W:1]);
   assign zero_d = pass_d[0];

   // a2 = a_i / 2 rounded half away from zero
   logic [IN_W:0]        ai_mag;
   logic [IN_W:0]        half_mag;
   logic signed [IN_W:0] half;

   assign ai_mag   = ai_d[IN_W-1] ? (IN_W+1)'(-(IN_W+1)'(ai_d)) : (IN_W+1)'(ai_d);
   assign half_mag = (ai_mag + (IN_W+1)'(1)) >> 1;
   assign half     = ai_d[IN_W-1] ? -$signed(half_mag) : $signed(half_mag);

   // ---------------------------------------------------------------
   // Stage 68: response register; a zero duration forces all zeros.
   // ---------------------------------------------------------------
   logic signed [COEF_W-1:0] coef0_ff, coef1_ff, coef2_ff;
   logic signed [COEF_W-1:0] coef3_ff, coef4_ff, coef5_ff;
   status_type               status_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         if (zero_d) begin
            coef0_ff  <= '0;
            coef1_ff  <= '0;
            coef2_ff  <= '0;
            coef3_ff  <= '0;
            coef4_ff  <= '0;
            coef5_ff  <= '0;
            status_ff <= STATUS_ZERO_DURATION;
         end else begin
            coef0_ff  <= COEF_W'(si_d);
            coef1_ff  <= COEF_W'(vi_d);
            coef2_ff  <= COEF_W'(half);
            coef3_ff  <= a3;
            coef4_ff  <= a4;
            coef5_ff  <= a5;
            status_ff <= (sat3 || sat4 || sat5) ? STATUS_SATURATED : STATUS_OK;
         end
      end
   end

   assign rsp_chan.valid  = rsp_valid_ff;
   assign rsp_chan.coef0  = coef0_ff;
   assign rsp_chan.coef1  = coef1_ff;
   assign rsp_chan.coef2  = coef2_ff;
   assign rsp_chan.coef3  = coef3_ff;
   assign rsp_chan.coef4  = coef4_ff;
   assign rsp_chan.coef5  = coef5_ff;
   assign rsp_chan.status = status_ff;

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 1ps
module testbench;
   import qjm_pkg::*;

   localparam int FRAC      = 16;
   localparam int LIMIT     = 400000;
   localparam int DRAIN     = 80;
   localparam int RAND_ITEMS = 1830;

   typedef logic signed [255:0] wide_type;

   typedef struct {
      logic signed [IN_W-1:0] start_position, start_velocity, start_accel;
      logic signed [IN_W-1:0] end_position, end_velocity, end_accel;
      logic [DUR_W-1:0]       duration;
   } traj_req_type;

   typedef struct {
      logic signed [COEF_W-1:0] coef[6];
      status_type               status;
   } traj_coef_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   qjm_req_if req_chan ();
   qjm_rsp_if rsp_chan ();

   quintic_jerk_min_trajectory #(.FRAC_BITS(FRAC)) uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   traj_coef_type pending_coefs[$];
   int errors      = 0;
   int sent_count  = 0;
   int recv_count  = 0;
   int zero_count  = 0;
   int sat_count   = 0;
   int cycles      = 0;
   int burst_left  = 0;

   // Round |num/den| to nearest, ties away from zero, then clamp to 48 bits.
   function automatic logic [COEF_W-1:0] round_clamp(wide_type num, wide_type den,
                                                     inout bit sat);
      bit       neg;
      wide_type mag, quot, lim;
      neg  = num < 0;
      mag  = neg ? -num : num;
      quot = (2 * mag + den) / (2 * den);
      lim  = neg ? (wide_type'(1) <<< 47) : ((wide_type'(1) <<< 47) - 1);
      if (quot > lim) begin
         quot = lim;
         sat  = 1'b1;
      end
      return neg ? -quot[COEF_W-1:0] : quot[COEF_W-1:0];
   endfunction

   // Exact closed form of the jerk-minimizing quintic for one request.
   function automatic traj_coef_type solve_quintic(traj_req_type r);
      traj_coef_type res;
      wide_type d, t, t2, t3, t4, t5, si, vi, ai, sf, vf, af;
      wide_type c0, c1, c2, c1t, c2t2, n3, n4, n5;
      longint a;
      bit sat;
      sat = 1'b0;
      if (r.duration == 0) begin
         foreach (res.coef[k]) res.coef[k] = '0;
         res.status = STATUS_ZERO_DURATION;
         return res;
      end
      d  = wide_type'(1) <<< FRAC;
      t  = wide_type'({232'b0, r.duration});
      t2 = t * t;  t3 = t2 * t;  t4 = t3 * t;  t5 = t4 * t;
      si = wide_type'(r.start_position); vi = wide_type'(r.start_velocity);
      ai = wide_type'(r.start_accel);    sf = wide_type'(r.end_position);
      vf = wide_type'(r.end_velocity);   af = wide_type'(r.end_accel);
      c0 = 2 * d * d * (sf - si) - 2 * d * vi * t - ai * t2;
      c1 = d * (vf - vi) - ai * t;
      c2 = af - ai;
      c1t  = c1 * t;
      c2t2 = c2 * t2;
      n3 = 10 * c0 - 8 * c1t + c2t2;
      n4 = -15 * c0 + 14 * c1t - 2 * c2t2;
      n5 = 6 * c0 - 6 * c1t + c2t2;
      res.coef[3] = round_clamp(d * n3, 2 * t3, sat);
      res.coef[4] = round_clamp(d * d * n4, 2 * t4, sat);
      res.coef[5] = round_clamp(d * d * d * n5, 2 * t5, sat);
      res.coef[0] = COEF_W'(r.start_position);
      res.coef[1] = COEF_W'(r.start_velocity);
      // halve the start acceleration, ties away from zero
      a = longint'(r.start_accel);
      res.coef[2] = COEF_W'((a < 0) ? -((-a + 1) / 2) : (a + 1) / 2);
      res.status = sat ? STATUS_SATURATED : STATUS_OK;
      return res;
   endfunction

   task automatic report_mismatch(string field, logic [COEF_W-1:0] got,
                                  logic [COEF_W-1:0] want);
      $display("ERROR @%0t transaction %0d: %s got %h expected %h",
               $time, recv_count, field, got, want);
      errors++;
   endtask

   // Drive one request; bursts of back-to-back transactions, random gaps between.
   task automatic send_traj(traj_req_type r);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_chan.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_chan.valid          <= 1'b1;
      req_chan.start_position <= r.start_position;
      req_chan.start_velocity <= r.start_velocity;
      req_chan.start_accel    <= r.start_accel;
      req_chan.end_position   <= r.end_position;
      req_chan.end_velocity   <= r.end_velocity;
      req_chan.end_accel      <= r.end_accel;
      req_chan.duration       <= r.duration;
      do @(posedge clock); while (!req_chan.ready);
      pending_coefs.push_back(solve_quintic(r));
      sent_count++;
   endtask

   // Hold the request side idle until every outstanding result is back.
   task automatic drain_all();
      req_chan.valid <= 1'b0;
      burst_left = 0;
      while (pending_coefs.size() != 0) @(posedge clock);
   endtask

   function automatic traj_req_type make_req(int s0, int v0, int a0, int s1,
                                             int v1, int a1, int dur);
      traj_req_type r;
      r.start_position = s0; r.start_velocity = v0; r.start_accel = a0;
      r.end_position   = s1; r.end_velocity   = v1; r.end_accel   = a1;
      r.duration       = dur[DUR_W-1:0];
      return r;
   endfunction

   // Receiver stall pattern: cycle through always-ready, random and bursty modes.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         case ((cycles / 1500) % 3)
            0: rsp_chan.ready <= 1'b1;
            1: rsp_chan.ready <= ($urandom_range(0, 9) < 7);
            default: rsp_chan.ready <= ((cycles % 16) < 10);
         endcase
      end
      if (cycles > LIMIT) begin
         $display("Timeout after %0d cycles", cycles);
         $display("Simulation FAILED");
         $finish;
      end
   end

   // Compare each accepted result against the oldest expectation.
   always @(posedge clock) begin
      traj_coef_type want;
      logic [COEF_W-1:0] got[6];
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got = '{rsp_chan.coef0, rsp_chan.coef1, rsp_chan.coef2,
                 rsp_chan.coef3, rsp_chan.coef4, rsp_chan.coef5};
         if (pending_coefs.size() == 0) begin
            $display("ERROR @%0t: result with nothing outstanding", $time);
            errors++;
         end else begin
            want = pending_coefs.pop_front();
            foreach (got[k])
               if (got[k] !== want.coef[k])
                  report_mismatch($sformatf("coef%0d", k), got[k], want.coef[k]);
            if (rsp_chan.status !== want.status)
               report_mismatch("status", COEF_W'(rsp_chan.status),
                               COEF_W'(want.status));
            if (want.status == STATUS_ZERO_DURATION) zero_count++;
            if (want.status == STATUS_SATURATED) sat_count++;
         end
         recv_count++;
      end
   end

   task automatic test_zero_duration();
      send_traj(make_req(32'h7fffffff, -5, 3, 100, 7, -9, 0));
      send_traj(make_req(-1, -1, -1, -1, -1, -1, 0));
   endtask

   task automatic test_field_extremes();
      int mx, mn;
      mx = 32'h7fffffff;
      mn = 32'h80000000;
      send_traj(make_req(mx, mx, mx, mx, mx, mx, 24'hffffff));
      send_traj(make_req(mn, mn, mn, mn, mn, mn, 24'hffffff));
      send_traj(make_req(mn, mx, mn, mx, mn, mx, 24'hffffff));
      send_traj(make_req(mx, mn, mx, mn, mx, mn, 1));
      send_traj(make_req(0, 0, 0, 0, 0, 0, 1));
      send_traj(make_req(0, 0, 0, 0, 0, 0, 24'hffffff));
   endtask

   task automatic test_saturation();
      // tiny duration forces the higher coefficients out of range
      send_traj(make_req(0, 0, 0, 32'h10000, 0, 0, 1));
      send_traj(make_req(0, 0, 0, -32'sh10000, 0, 0, 2));
      send_traj(make_req(0, 32'h10000, 0, 0, 0, 0, 16));
   endtask

   task automatic test_rounding();
      // odd accelerations exercise half-value rounding in both signs
      send_traj(make_req(0, 0, 1, 0, 0, 0, 32'h10000));
      send_traj(make_req(0, 0, -1, 0, 0, 0, 32'h10000));
      send_traj(make_req(0, 0, -3, 0, 0, 0, 32'h10000));
      send_traj(make_req(0, 0, 3, 7, -3, 5, 32'h30000));
      // plain rest-to-rest move of one unit over one second
      send_traj(make_req(0, 0, 0, 32'h10000, 0, 0, 32'h10000));
      send_traj(make_req(32'h50000, 32'h8000, -32'sh4000, -32'sh20000, 32'h1000,
                         32'h2000, 32'h28000));
   endtask

   task automatic test_random(int count);
      traj_req_type r;
      int mode, span;
      repeat (count) begin
         mode = $urandom_range(0, 9);
         if (mode < 6) begin
            // realistic move: moderate magnitudes, durations around seconds
            span = $urandom_range(8, 28);
            r = make_req($urandom_range(0, 1 << span) - (1 << (span - 1)),
                         $urandom_range(0, 1 << span) - (1 << (span - 1)),
                         $urandom_range(0, 1 << span) - (1 << (span - 1)),
                         $urandom_range(0, 1 << span) - (1 << (span - 1)),
                         $urandom_range(0, 1 << span) - (1 << (span - 1)),
                         $urandom_range(0, 1 << span) - (1 << (span - 1)),
                         $urandom_range(32'h1000, 32'h80000));
         end else begin
            r = make_req($urandom, $urandom, $urandom, $urandom, $urandom,
                         $urandom, $urandom);
            if (mode == 9) r.duration = $urandom_range(0, 3);
         end
         send_traj(r);
      end
   endtask

   initial begin
      req_chan.valid          = 1'b0;
      req_chan.start_position = '0;
      req_chan.start_velocity = '0;
      req_chan.start_accel    = '0;
      req_chan.end_position   = '0;
      req_chan.end_velocity   = '0;
      req_chan.end_accel      = '0;
      req_chan.duration       = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_zero_duration();
      test_field_extremes();
      drain_all();
      test_saturation();
      test_rounding();
      drain_all();
      test_random(RAND_ITEMS / 2);
      drain_all();
      test_random(RAND_ITEMS - RAND_ITEMS / 2);
      drain_all();
      repeat (DRAIN) @(posedge clock);

      $display("Covered %0d trajectory requests, %0d results checked", sent_count,
               recv_count);
      $display("Zero-duration results: %0d, saturated results: %0d, mismatches: %0d",
               zero_count, sat_count, errors);
      if (errors == 0 && pending_coefs.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

FILE: quintic_jerk_min_trajectory.f
hw/rtl/qjm_pkg.sv
hw/rtl/qjm_req_if.sv
hw/rtl/qjm_rsp_if.sv
hw/rtl/qjm_dly.sv
hw/rtl/qjm_mul.sv
hw/rtl/qjm_div.sv
hw/rtl/quintic_jerk_min_trajectory.sv
dv/testbench.sv
